@@ hw/rtl/mbrc_pkg.sv @@
// Shared types, constants and the CRC step for the Modbus read response checker.
package mbrc_pkg;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_ADDR_ERR    = 3'd1,
    ST_FUNC_ERR    = 3'd2,
    ST_CRC_ERR     = 3'd3,
    ST_TOO_SHORT   = 3'd4,
    ST_READ_REPLY  = 3'd5
  } status_t;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HR  = 8'h03;
  localparam logic [7:0]  POS_SAT       = 8'd255;
  localparam logic [7:0]  MIN_FRAME_LEN = 8'd5;

  // Reflected CRC-16 over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/modbus_read_response_checker_core.sv @@
// Modbus RTU read-holding-registers response checker: CRC, header checks, register table.
// Results are registered: a result item appears in the cycle after the item that causes it is accepted.
// Throughput: one item per cycle; frame bytes without the end mark are taken even while
// a result waits on a stalled output, result-causing items wait for the output register.
// Commit flips per-entry bank bits of a two-bank table, so a frame's words commit together, without copying.
// Reset (rst, synchronous): frame state cleared, table reads as zero, slave address 1.
module modbus_read_response_checker_core #(
  parameter int MAX_REGS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_frame,
  input  logic [4:0]  reg_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [5:0]  reg_count,
  output logic [15:0] read_value
);

  localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam logic [6:0] MaxRegs7 = 7'(MAX_REGS);
  localparam logic [7:0] MaxRegs8 = 8'(MAX_REGS);

  // configuration
  logic [7:0] slave_address;

  // frame state
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  frame_position, frame_position_next;
  logic [7:0]  header_address, header_address_next;
  logic [7:0]  header_function, header_function_next;
  logic [7:0]  declared_byte_count, declared_byte_count_next;
  logic [7:0]  pending_high_byte, pending_high_byte_next;

  // two banks; live selects the committed bank, entry_valid marks committed entries
  logic [15:0] bank_a [MAX_REGS];
  logic [15:0] bank_b [MAX_REGS];
  logic [MAX_REGS-1:0] live;
  logic [MAX_REGS-1:0] entry_valid;

  // read capture
  logic        rd_is_read;
  logic        rd_ok;
  logic        rd_sel;
  logic [15:0] rd_a, rd_b;

  logic    accept, has_result, byte_item;
  logic    stage_we;
  logic [7:0]    word_full;
  logic [AW-1:0] wr_addr;
  logic [6:0]    idx7;
  logic          rd_in_range;
  logic [AW-1:0] rd_addr;
  logic [6:0]    half_len, half_cnt, count;
  logic          commit;
  mbrc_pkg::status_t frame_status;

  assign has_result = command | end_of_frame;
  assign in_stall   = out_valid & out_stall & has_result;
  assign accept     = in_valid & ~in_stall;
  assign byte_item  = accept & ~command;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
    end else if (cfg_we) begin
      slave_address <= cfg_wdata;
    end
  end

  // frame byte decode
  always_comb begin
    running_crc_next         = mbrc_pkg::crc_byte(running_crc, rx_byte);
    header_address_next      = header_address;
    header_function_next     = header_function;
    declared_byte_count_next = declared_byte_count;
    pending_high_byte_next   = pending_high_byte;
    stage_we                 = 1'b0;
    word_full                = 8'(frame_position - 8'd4) >> 1;
    case (frame_position)
      8'd0: header_address_next = rx_byte;
      8'd1: header_function_next = rx_byte;
      8'd2: declared_byte_count_next = rx_byte;
      default: begin
        if (frame_position != mbrc_pkg::POS_SAT) begin
          if (frame_position[0]) begin
            pending_high_byte_next = rx_byte;
          end else begin
            stage_we = (word_full < MaxRegs8);
          end
        end
      end
    endcase
    frame_position_next = (frame_position == mbrc_pkg::POS_SAT) ?
                          frame_position : 8'(frame_position + 8'd1);
  end

  assign wr_addr = word_full[AW-1:0];

  // end-of-frame checks and word count
  always_comb begin
    half_len = 7'((frame_position_next - mbrc_pkg::MIN_FRAME_LEN) >> 1);
    half_cnt = declared_byte_count_next[7:1];
    count    = half_cnt;
    if (half_len < count) count = half_len;
    if (MaxRegs7 < count) count = MaxRegs7;
    if (frame_position_next < mbrc_pkg::MIN_FRAME_LEN) begin
      frame_status = mbrc_pkg::ST_TOO_SHORT;
    end else if (header_address_next != slave_address) begin
      frame_status = mbrc_pkg::ST_ADDR_ERR;
    end else if (header_function_next != mbrc_pkg::FUNC_READ_HR) begin
      frame_status = mbrc_pkg::ST_FUNC_ERR;
    end else if (running_crc_next != 16'h0000) begin
      frame_status = mbrc_pkg::ST_CRC_ERR;
    end else begin
      frame_status = mbrc_pkg::ST_ACCEPTED;
    end
  end

  assign commit = byte_item & end_of_frame & (frame_status == mbrc_pkg::ST_ACCEPTED);

  always_ff @(posedge clk) begin
    if (rst || (byte_item && end_of_frame)) begin
      running_crc         <= mbrc_pkg::CRC_INIT;
      frame_position      <= 8'd0;
      header_address      <= 8'd0;
      header_function     <= 8'd0;
      declared_byte_count <= 8'd0;
      pending_high_byte   <= 8'd0;
    end else if (byte_item) begin
      running_crc         <= running_crc_next;
      frame_position      <= frame_position_next;
      header_address      <= header_address_next;
      header_function     <= header_function_next;
      declared_byte_count <= declared_byte_count_next;
      pending_high_byte   <= pending_high_byte_next;
    end
  end

  // stage into the bank that is not live for that entry
  always_ff @(posedge clk) begin
    if (byte_item && stage_we) begin
      if (live[wr_addr]) begin
        bank_a[wr_addr] <= {pending_high_byte, rx_byte};
      end else begin
        bank_b[wr_addr] <= {pending_high_byte, rx_byte};
      end
    end
  end

  // commit: flip the first count entries over to their staged bank
  always_ff @(posedge clk) begin
    if (rst) begin
      live        <= '0;
      entry_valid <= '0;
    end else if (commit) begin
      for (int k = 0; k < MAX_REGS; k++) begin
        if (7'(k) < count) begin
          live[k]        <= ~live[k];
          entry_valid[k] <= 1'b1;
        end
      end
    end
  end

  assign idx7        = {2'b00, reg_index};
  assign rd_in_range = (idx7 < MaxRegs7);
  assign rd_addr     = idx7[AW-1:0];

  always_ff @(posedge clk) begin
    if (accept && command && rd_in_range) begin
      rd_a <= bank_a[rd_addr];
      rd_b <= bank_b[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      rd_is_read <= command;
      rd_ok      <= rd_in_range ? entry_valid[rd_addr] : 1'b0;
      rd_sel     <= rd_in_range ? live[rd_addr] : 1'b0;
      if (command) begin
        status    <= mbrc_pkg::ST_READ_REPLY;
        reg_count <= 6'd0;
      end else begin
        status    <= frame_status;
        reg_count <= (frame_status == mbrc_pkg::ST_ACCEPTED) ? count[5:0] : 6'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // live bit 1 means bank b holds the committed word
  assign read_value = (rd_is_read && rd_ok) ? (rd_sel ? rd_b : rd_a) : 16'h0000;

`ifndef SYNTHESIS
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");

  a_reject_no_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != mbrc_pkg::ST_ACCEPTED) |-> (reg_count == 6'd0))
    else $error("nonzero count on rejected frame or read");

  a_value_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != mbrc_pkg::ST_READ_REPLY) |-> (read_value == 16'h0000))
    else $error("read value on frame result");

  a_frame_cleared_after_eof: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !command && end_of_frame) |=>
      (frame_position == 8'd0 && running_crc == mbrc_pkg::CRC_INIT))
    else $error("frame state not cleared after end of frame");
`endif

endmodule

@@ dv/modbus_read_response_checker_core_tb.sv @@
// Testbench for the Modbus read response checker: frames, register reads, stalls, self-checked.
`timescale 1ns / 100ps

typedef struct {
  mbrc_pkg::status_t status;
  logic [5:0]        count;
  logic [15:0]       value;
} reply_t;

// Tracks frame state and the register table, and holds the replies still due.
class response_tracker;
  localparam int TABLE_WORDS = 32;

  logic [7:0]  slave_addr;
  logic [15:0] crc;
  int unsigned pos;
  logic [7:0]  hdr_addr;
  logic [7:0]  hdr_func;
  logic [7:0]  byte_count;
  logic [7:0]  high_byte;
  logic [15:0] staged [TABLE_WORDS];
  logic [15:0] reg_table [TABLE_WORDS];
  reply_t      replies_due [$];
  int unsigned mismatches;
  int unsigned n_accepted;
  int unsigned n_rejected;
  int unsigned n_reads;

  function new();
    slave_addr = 8'd1;
    clear_frame();
    foreach (reg_table[i]) begin
      reg_table[i] = '0;
      staged[i] = '0;
    end
    mismatches = 0;
    n_accepted = 0;
    n_rejected = 0;
    n_reads = 0;
  endfunction

  function void clear_frame();
    crc = mbrc_pkg::CRC_INIT;
    pos = 0;
    hdr_addr = '0;
    hdr_func = '0;
    byte_count = '0;
    high_byte = '0;
  endfunction

  // Bit-serial form of the reflected CRC-16.
  function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ mbrc_pkg::CRC_POLY;
    end
    return c;
  endfunction

  function void take_item(logic cmd, logic [7:0] b, logic eof, logic [4:0] idx);
    reply_t      r;
    int unsigned len;
    int unsigned cnt;
    r.count = '0;
    r.value = '0;
    if (cmd) begin
      r.status = mbrc_pkg::ST_READ_REPLY;
      if (idx < TABLE_WORDS) r.value = reg_table[idx];
      replies_due.push_back(r);
      return;
    end
    crc = crc_update(crc, b);
    if (pos == 0) hdr_addr = b;
    else if (pos == 1) hdr_func = b;
    else if (pos == 2) byte_count = b;
    else if (pos < 255) begin
      if ((pos - 3) % 2 == 0) high_byte = b;
      else if ((pos - 4) / 2 < TABLE_WORDS) staged[(pos - 4) / 2] = {high_byte, b};
    end
    if (pos < 255) pos++;
    if (!eof) return;
    len = pos;
    if (len < mbrc_pkg::MIN_FRAME_LEN) r.status = mbrc_pkg::ST_TOO_SHORT;
    else if (hdr_addr != slave_addr) r.status = mbrc_pkg::ST_ADDR_ERR;
    else if (hdr_func != mbrc_pkg::FUNC_READ_HR) r.status = mbrc_pkg::ST_FUNC_ERR;
    else if (crc != 16'h0000) r.status = mbrc_pkg::ST_CRC_ERR;
    else begin
      r.status = mbrc_pkg::ST_ACCEPTED;
      cnt = byte_count / 2;
      if ((len - 5) / 2 < cnt) cnt = (len - 5) / 2;
      if (cnt > TABLE_WORDS) cnt = TABLE_WORDS;
      for (int k = 0; k < cnt; k++) reg_table[k] = staged[k];
      r.count = 6'(cnt);
    end
    clear_frame();
    replies_due.push_back(r);
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    // Keep the log short when the block is badly off.
    if (mismatches <= 30) $display("MISMATCH: %s", msg);
  endtask

  task check_reply(logic [2:0] st, logic [5:0] cnt, logic [15:0] val);
    reply_t r;
    if (replies_due.size() == 0) begin
      report_mismatch($sformatf("result with none due: status %0d count %0d value %h",
                                st, cnt, val));
      return;
    end
    r = replies_due.pop_front();
    if (r.status == mbrc_pkg::ST_ACCEPTED) n_accepted++;
    else if (r.status == mbrc_pkg::ST_READ_REPLY) n_reads++;
    else n_rejected++;
    if (st !== r.status)
      report_mismatch($sformatf("status %0d, want %s", st, r.status.name()));
    if (cnt !== r.count)
      report_mismatch($sformatf("reg_count %0d, want %0d (%s)", cnt, r.count,
                                r.status.name()));
    if (val !== r.value)
      report_mismatch($sformatf("read_value %h, want %h (%s)", val, r.value,
                                r.status.name()));
  endtask
endclass

module modbus_read_response_checker_core_tb;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        command = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        end_of_frame = 1'b0;
  logic [4:0]  reg_index = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  status;
  logic [5:0]  reg_count;
  logic [15:0] read_value;

  response_tracker trk;
  logic [7:0]      frame_q [$];
  int              send_idle_pct = 19;
  int              recv_idle_pct = 48;
  int unsigned     items_sent = 0;
  int unsigned     frames_sent = 0;
  int unsigned     cycles = 0;
  bit              long_done = 1'b0;

  modbus_read_response_checker_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .rx_byte      (rx_byte),
    .end_of_frame (end_of_frame),
    .reg_index    (reg_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .reg_count    (reg_count),
    .read_value   (read_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies still due", cycles,
               trk.replies_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) trk.check_reply(status, reg_count, read_value);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_item(input logic cmd, input logic [7:0] b, input logic eof,
                           input logic [4:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    rx_byte <= b;
    end_of_frame <= eof;
    reg_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    trk.take_item(cmd, b, eof, idx);
    items_sent++;
  endtask

  task automatic send_read();
    send_item(1'b1, 8'($urandom), 1'($urandom), 5'($urandom));
  endtask

  // Send frame_q, mark the last byte, and slip reads in between bytes now and then.
  task automatic send_frame(input int read_pct);
    int last;
    last = frame_q.size() - 1;
    for (int i = 0; i <= last; i++) begin
      if ($urandom_range(99) < read_pct) send_read();
      send_item(1'b0, frame_q[i], i == last, 5'($urandom));
    end
    frames_sent++;
  endtask

  task automatic add_crc();
    logic [15:0] c;
    c = mbrc_pkg::CRC_INIT;
    foreach (frame_q[i]) c = trk.crc_update(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  task automatic make_response(input logic [7:0] addr, input logic [7:0] func,
                               input logic [7:0] bc, input int n_data);
    frame_q.delete();
    frame_q.push_back(addr);
    frame_q.push_back(func);
    frame_q.push_back(bc);
    repeat (n_data) frame_q.push_back(8'($urandom));
    add_crc();
  endtask

  task automatic random_frame();
    int         kind;
    int         n;
    int         nbytes;
    int         flip;
    logic [7:0] bc;
    kind = $urandom_range(99);
    n = ($urandom_range(9) == 0) ? $urandom_range(33, 45) : $urandom_range(0, 6);
    nbytes = 2 * n + (($urandom_range(9) == 0) ? 1 : 0);
    bc = ($urandom_range(4) == 0) ? 8'($urandom) : 8'(2 * n);
    if (kind < 55) begin
      make_response(trk.slave_addr, mbrc_pkg::FUNC_READ_HR, bc, nbytes);
    end else if (kind < 65) begin
      make_response(trk.slave_addr ^ 8'($urandom_range(1, 255)), mbrc_pkg::FUNC_READ_HR,
                    bc, nbytes);
    end else if (kind < 75) begin
      make_response(trk.slave_addr, mbrc_pkg::FUNC_READ_HR ^ 8'($urandom_range(1, 255)),
                    bc, nbytes);
    end else if (kind < 85) begin
      // Corrupt one bit past the address and function bytes so only the CRC can catch it.
      make_response(trk.slave_addr, mbrc_pkg::FUNC_READ_HR, bc, nbytes);
      flip = $urandom_range(2, frame_q.size() - 1);
      frame_q[flip] = frame_q[flip] ^ (8'd1 << $urandom_range(7));
    end else if (kind < 92) begin
      frame_q.delete();
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
      if ($urandom_range(1) == 1) frame_q[0] = trk.slave_addr;
    end else begin
      frame_q.delete();
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
    end
    send_frame(8);
  endtask

  // Hold the sender until every reply due has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (trk.replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_address(input logic [7:0] addr);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    trk.slave_addr = addr;
  endtask

  task automatic run_phase(input int target, input int s_pct, input int r_pct,
                           input bit with_long);
    int unsigned stop;
    stop = items_sent + target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (items_sent < stop) begin
      if ($urandom_range(39) == 0) drain();
      if (with_long && !long_done && items_sent >= stop - target / 2) begin
        // Run past the saturating position counter with a valid CRC.
        make_response(trk.slave_addr, mbrc_pkg::FUNC_READ_HR, 8'($urandom_range(64, 255)),
                      $urandom_range(252, 290));
        send_frame(2);
        long_done = 1'b1;
      end else if ($urandom_range(4) == 0) begin
        send_read();
      end else begin
        random_frame();
      end
    end
  endtask

  initial begin
    trk = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Table reads zero after reset, at both ends of the index range.
    send_item(1'b1, 8'h00, 1'b0, 5'd0);
    send_item(1'b1, 8'hFF, 1'b1, 5'd31);
    // One-byte frame.
    send_item(1'b0, 8'hFF, 1'b1, 5'd31);
    // Shortest good frame: no data words.
    make_response(8'h01, mbrc_pkg::FUNC_READ_HR, 8'h00, 0);
    send_frame(0);
    // One all-ones word, with a read carrying a stray end mark in mid-frame.
    frame_q = '{8'h01, mbrc_pkg::FUNC_READ_HR, 8'h02, 8'hFF, 8'hFF};
    add_crc();
    for (int i = 0; i < frame_q.size(); i++) begin
      if (i == 3) send_item(1'b1, 8'h00, 1'b1, 5'd31);
      send_item(1'b0, frame_q[i], i == frame_q.size() - 1, 5'd0);
    end
    frames_sent++;
    send_item(1'b1, 8'h00, 1'b0, 5'd0);
    // Wrong function code.
    frame_q = '{8'h01, 8'h00, 8'h00};
    add_crc();
    send_frame(0);

    set_address(8'h00);
    run_phase(220, 19, 48, 1'b0);
    set_address(8'hFF);
    run_phase(220, 48, 19, 1'b0);
    set_address(8'($urandom_range(2, 254)));
    run_phase(220, 0, 0, 1'b1);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items in %0d frames: %0d accepted, %0d rejected, %0d register reads",
             items_sent, frames_sent, trk.n_accepted, trk.n_rejected, trk.n_reads);
    $display("Slave address 1, 0, 255 and one random value; stalls on both sides, then none");
    if (trk.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", trk.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
